// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// Types, widths and register map of the mecanum wheel mixer.
// ----------------------------------------------------------------------------
package mwm_pkg;

    localparam int WHEELS      = 4;
    localparam int IN_W        = 16;
    localparam int SUM_W       = IN_W + 2;
    localparam int MAG_W       = SUM_W - 1;
    localparam int LIM_W       = 15;
    localparam int GAIN_W      = 24;
    localparam int RPM_W       = 16;
    localparam int QUO_W       = LIM_W;
    localparam int NUM_W       = MAG_W + LIM_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int PROD_W      = MAG_W + GAIN_W + 1;
    localparam int ROUND_SHIFT = 20;
    localparam int RND_W       = PROD_W - ROUND_SHIFT;
    localparam int NSTAGES     = 3 + (DIV_STEPS + 1) + 2;

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [LIM_W-1:0]  MAX_SPEED_RESET = LIM_W'(12288);
    localparam logic [GAIN_W-1:0] GAIN_RESET      = GAIN_W'(609536);
    localparam logic [LIM_W-1:0]  MAX_RPM_RESET   = LIM_W'(7000);

    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

    localparam int WHEEL_LF = 0;
    localparam int WHEEL_LB = 1;
    localparam int WHEEL_RF = 2;
    localparam int WHEEL_RB = 3;

    typedef enum logic [APB_ADDR_W-1:0] {
        ADDR_MAX_SPEED = 4'h0,
        ADDR_GAIN      = 4'h4,
        ADDR_MAX_RPM   = 4'h8
    } reg_addr_t;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [MAG_W-1:0]        mag_t;

    typedef struct packed {
        mag_t             rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        mag_t             mag;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        div_lane_t [WHEELS-1:0] lane;
        mag_t                   divisor;
        logic                   scale;
    } div_stage_t;

endpackage

// ===== src/mecanum_wheel_mixer.sv =====
// Pipeline of 21 register stages. Throughput: one request per cycle while the
// result is not stalled; the per-wheel scaling divider is a 15-stage pipeline,
// one quotient bit per stage.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// Mixes chassis speed into four mecanum wheel speeds, scales them down to the
// chassis speed limit when the largest exceeds it, converts to rpm and clamps to the rpm limit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mecanum_wheel_mixer (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwm_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mwm_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mwm_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,

    input  logic                                cmd_valid,
    output logic                                cmd_stall,
    input  logic signed [mwm_pkg::IN_W-1:0]     speed_horizontal,
    input  logic signed [mwm_pkg::IN_W-1:0]     speed_vertical,
    input  logic signed [mwm_pkg::IN_W-1:0]     speed_rotation,

    output logic                                rpm_valid,
    input  logic                                rpm_stall,
    output logic signed [mwm_pkg::RPM_W-1:0]    lf_rpm,
    output logic signed [mwm_pkg::RPM_W-1:0]    lb_rpm,
    output logic signed [mwm_pkg::RPM_W-1:0]    rf_rpm,
    output logic signed [mwm_pkg::RPM_W-1:0]    rb_rpm
);

    localparam int W  = mwm_pkg::WHEELS;
    localparam int NS = mwm_pkg::NSTAGES;
    localparam int DS = mwm_pkg::DIV_STEPS;
    localparam int QW = mwm_pkg::QUO_W;
    localparam int MW = mwm_pkg::MAG_W;

    // configuration
    logic [mwm_pkg::LIM_W-1:0]  max_speed_reg;
    logic [mwm_pkg::GAIN_W-1:0] gain_reg;
    logic [mwm_pkg::LIM_W-1:0]  max_rpm_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg <= mwm_pkg::MAX_SPEED_RESET;
            gain_reg      <= mwm_pkg::GAIN_RESET;
            max_rpm_reg   <= mwm_pkg::MAX_RPM_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr)
                mwm_pkg::ADDR_MAX_SPEED: max_speed_reg <= pwdata[mwm_pkg::LIM_W-1:0];
                mwm_pkg::ADDR_GAIN:      gain_reg      <= pwdata[mwm_pkg::GAIN_W-1:0];
                mwm_pkg::ADDR_MAX_RPM:   max_rpm_reg   <= pwdata[mwm_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            mwm_pkg::ADDR_MAX_SPEED: prdata = mwm_pkg::APB_DATA_W'(max_speed_reg);
            mwm_pkg::ADDR_GAIN:      prdata = mwm_pkg::APB_DATA_W'(gain_reg);
            mwm_pkg::ADDR_MAX_RPM:   prdata = mwm_pkg::APB_DATA_W'(max_rpm_reg);
            default:                 prdata = '0;
        endcase
    end

    // pipeline control: whole pipe freezes on a stalled result
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic          pipe_en;

    assign rpm_valid  = valid_reg[NS-1];
    assign pipe_en    = !(rpm_valid && rpm_stall);
    assign cmd_stall  = !pipe_en;
    assign valid_next = {valid_reg[NS-2:0], cmd_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= valid_next;
        end
    end

    // stage 1: wheel sums
    mwm_pkg::sum_t sum_reg [W];
    mwm_pkg::sum_t sum_next [W];
    mwm_pkg::sum_t h_ext;
    mwm_pkg::sum_t v_ext;
    mwm_pkg::sum_t r_ext;

    always_comb
    begin
        h_ext = mwm_pkg::SUM_W'(speed_horizontal);
        v_ext = mwm_pkg::SUM_W'(speed_vertical);
        r_ext = mwm_pkg::SUM_W'(speed_rotation);
        sum_next[mwm_pkg::WHEEL_LF] =  h_ext + v_ext + r_ext;
        sum_next[mwm_pkg::WHEEL_LB] = -h_ext + v_ext + r_ext;
        sum_next[mwm_pkg::WHEEL_RF] = -h_ext + v_ext - r_ext;
        sum_next[mwm_pkg::WHEEL_RB] =  h_ext + v_ext - r_ext;
    end

    // stage 2: sign and magnitude
    mwm_pkg::mag_t mag2_reg [W];
    mwm_pkg::mag_t mag2_next [W];
    logic [W-1:0]  neg2_reg;
    logic [W-1:0]  neg2_next;

    always_comb
    begin
        for (int k = 0; k < W; k++)
        begin
            neg2_next[k] = sum_reg[k][mwm_pkg::SUM_W-1];
            mag2_next[k] = neg2_next[k] ? MW'(-sum_reg[k]) : MW'(sum_reg[k]);
        end
    end

    // stage 3: largest magnitude
    mwm_pkg::mag_t mag3_reg [W];
    logic [W-1:0]  neg3_reg;
    mwm_pkg::mag_t max3_reg;
    mwm_pkg::mag_t max3_next;
    mwm_pkg::mag_t max01;
    mwm_pkg::mag_t max23;

    always_comb
    begin
        max01     = (mag2_reg[0] > mag2_reg[1]) ? mag2_reg[0] : mag2_reg[1];
        max23     = (mag2_reg[2] > mag2_reg[3]) ? mag2_reg[2] : mag2_reg[3];
        max3_next = (max01 > max23) ? max01 : max23;
    end

    // stage 4 (divider entry) and divider steps
    mwm_pkg::div_stage_t div_reg  [DS+1];
    mwm_pkg::div_stage_t div_next [DS+1];

    always_comb
    begin
        logic [mwm_pkg::NUM_W-1:0] num;
        logic [MW:0]               trial;
        logic                      qbit;
        div_next[0].divisor = max3_reg;
        div_next[0].scale   = max3_reg > MW'(max_speed_reg);
        for (int k = 0; k < W; k++)
        begin
            num = mwm_pkg::NUM_W'(mag3_reg[k]) * mwm_pkg::NUM_W'(max_speed_reg);
            div_next[0].lane[k].rem = num[mwm_pkg::NUM_W-1:QW];
            div_next[0].lane[k].low = num[QW-1:0];
            div_next[0].lane[k].quo = '0;
            div_next[0].lane[k].mag = mag3_reg[k];
            div_next[0].lane[k].neg = neg3_reg[k];
        end
        for (int d = 1; d <= DS; d++)
        begin
            div_next[d].divisor = div_reg[d-1].divisor;
            div_next[d].scale   = div_reg[d-1].scale;
            for (int k = 0; k < W; k++)
            begin
                trial = {div_reg[d-1].lane[k].rem, div_reg[d-1].lane[k].low[QW-1]};
                qbit  = trial >= {1'b0, div_reg[d-1].divisor};
                div_next[d].lane[k].rem = qbit ? MW'(trial - {1'b0, div_reg[d-1].divisor})
                                               : MW'(trial);
                div_next[d].lane[k].low = {div_reg[d-1].lane[k].low[QW-2:0], 1'b0};
                div_next[d].lane[k].quo = {div_reg[d-1].lane[k].quo[QW-2:0], qbit};
                div_next[d].lane[k].mag = div_reg[d-1].lane[k].mag;
                div_next[d].lane[k].neg = div_reg[d-1].lane[k].neg;
            end
        end
    end

    // rpm conversion multiply
    logic [mwm_pkg::PROD_W-1:0] prod_reg  [W];
    logic [mwm_pkg::PROD_W-1:0] prod_next [W];
    logic [W-1:0]               negp_reg;
    logic [W-1:0]               negp_next;
    mwm_pkg::mag_t              spd_sel;

    always_comb
    begin
        for (int k = 0; k < W; k++)
        begin
            spd_sel      = div_reg[DS].scale ? MW'(div_reg[DS].lane[k].quo)
                                             : div_reg[DS].lane[k].mag;
            prod_next[k] = mwm_pkg::PROD_W'(spd_sel) * mwm_pkg::PROD_W'(gain_reg);
            negp_next[k] = div_reg[DS].lane[k].neg;
        end
    end

    // round, clamp, sign
    logic signed [mwm_pkg::RPM_W-1:0] rpm_reg  [W];
    logic signed [mwm_pkg::RPM_W-1:0] rpm_next [W];

    always_comb
    begin
        logic [mwm_pkg::PROD_W-1:0] rounded;
        logic [mwm_pkg::RND_W-1:0]  rpm_mag;
        logic [mwm_pkg::LIM_W-1:0]  rpm_lim;
        for (int k = 0; k < W; k++)
        begin
            rounded = prod_reg[k] + mwm_pkg::ROUND_HALF;
            rpm_mag = rounded[mwm_pkg::PROD_W-1:mwm_pkg::ROUND_SHIFT];
            rpm_lim = (rpm_mag > mwm_pkg::RND_W'(max_rpm_reg)) ? max_rpm_reg
                                                                : rpm_mag[mwm_pkg::LIM_W-1:0];
            rpm_next[k] = negp_reg[k] ? -$signed({1'b0, rpm_lim}) : $signed({1'b0, rpm_lim});
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sum_reg  <= sum_next;
            mag2_reg <= mag2_next;
            neg2_reg <= neg2_next;
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            max3_reg <= max3_next;
            div_reg  <= div_next;
            prod_reg <= prod_next;
            negp_reg <= negp_next;
            rpm_reg  <= rpm_next;
        end
    end

    assign lf_rpm = rpm_reg[mwm_pkg::WHEEL_LF];
    assign lb_rpm = rpm_reg[mwm_pkg::WHEEL_LB];
    assign rf_rpm = rpm_reg[mwm_pkg::WHEEL_RF];
    assign rb_rpm = rpm_reg[mwm_pkg::WHEEL_RB];

    // checks
    logic signed [mwm_pkg::RPM_W-1:0] rpm_lim_s;
    logic                             div_rem_ok;
    logic                             div_chk;
    logic                             lf_in_lim;
    logic                             rb_in_lim;

    assign rpm_lim_s = $signed({1'b0, max_rpm_reg});
    assign div_chk   = valid_reg[NS-3] && div_reg[DS].scale;
    assign lf_in_lim = (lf_rpm <= rpm_lim_s) && (lf_rpm >= -rpm_lim_s);
    assign rb_in_lim = (rb_rpm <= rpm_lim_s) && (rb_rpm >= -rpm_lim_s);

    always_comb
    begin
        div_rem_ok = 1'b1;
        for (int k = 0; k < W; k++)
        begin
            if (div_reg[DS].lane[k].rem >= div_reg[DS].divisor)
            begin
                div_rem_ok = 1'b0;
            end
        end
    end

    `ASSERT_IMPLIES(a_lf_clamped, rpm_valid, lf_in_lim, "left front rpm outside limit")
    `ASSERT_IMPLIES(a_rb_clamped, rpm_valid, rb_in_lim, "right back rpm outside limit")
    `ASSERT_IMPLIES(a_div_rem, div_chk, div_rem_ok, "divider remainder not below divisor")
    `ASSERT_NEXT(a_freeze, cmd_stall, $stable(valid_reg), "pipeline moved while frozen")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mecanum_wheel_mixer: drives chassis speed requests,
// predicts the four clamped wheel rpm values per request and compares them
// in order against the block output under random gaps, stalls and long
// back-pressure, across several register settings written over APB.
// ----------------------------------------------------------------------------
module tb;

    localparam int PIPE_CYCLES = 21;
    localparam int HOLD_CYCLES = 300;
    localparam logic [mwm_pkg::APB_ADDR_W-1:0] ADDR_UNUSED = 4'hC;

    typedef logic [mwm_pkg::WHEELS-1:0][mwm_pkg::RPM_W-1:0] wheel_rpm_t;

    logic                             clk;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [mwm_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [mwm_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [mwm_pkg::APB_DATA_W-1:0]   prdata;
    logic                             pready;
    logic                             cmd_valid = 1'b0;
    logic                             cmd_stall;
    logic signed [mwm_pkg::IN_W-1:0]  speed_horizontal = '0;
    logic signed [mwm_pkg::IN_W-1:0]  speed_vertical = '0;
    logic signed [mwm_pkg::IN_W-1:0]  speed_rotation = '0;
    logic                             rpm_valid;
    logic                             rpm_stall = 1'b0;
    logic signed [mwm_pkg::RPM_W-1:0] lf_rpm;
    logic signed [mwm_pkg::RPM_W-1:0] lb_rpm;
    logic signed [mwm_pkg::RPM_W-1:0] rf_rpm;
    logic signed [mwm_pkg::RPM_W-1:0] rb_rpm;

    logic [mwm_pkg::LIM_W-1:0]  max_speed_cfg;
    logic [mwm_pkg::GAIN_W-1:0] gain_cfg;
    logic [mwm_pkg::LIM_W-1:0]  max_rpm_cfg;

    wheel_rpm_t pending_rpm[$];
    int         mismatches = 0;
    int         cmd_gap_pct = 0;
    int         rpm_stall_pct = 0;
    int         hold_left = 0;

    string wheel_name [mwm_pkg::WHEELS] = '{"lf_rpm", "lb_rpm", "rf_rpm", "rb_rpm"};

    mecanum_wheel_mixer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .cmd_valid        (cmd_valid),
        .cmd_stall        (cmd_stall),
        .speed_horizontal (speed_horizontal),
        .speed_vertical   (speed_vertical),
        .speed_rotation   (speed_rotation),
        .rpm_valid        (rpm_valid),
        .rpm_stall        (rpm_stall),
        .lf_rpm           (lf_rpm),
        .lb_rpm           (lb_rpm),
        .rf_rpm           (rf_rpm),
        .rb_rpm           (rb_rpm)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // mix, scale down to the chassis limit when exceeded, convert and clamp
    function automatic wheel_rpm_t mix_wheels(int h, int v, int r);
        longint     sum [mwm_pkg::WHEELS];
        longint     peak;
        longint     a;
        longint     rpm;
        wheel_rpm_t res;
        sum[mwm_pkg::WHEEL_LF] =  longint'(h) + longint'(v) + longint'(r);
        sum[mwm_pkg::WHEEL_LB] = -longint'(h) + longint'(v) + longint'(r);
        sum[mwm_pkg::WHEEL_RF] = -longint'(h) + longint'(v) - longint'(r);
        sum[mwm_pkg::WHEEL_RB] =  longint'(h) + longint'(v) - longint'(r);
        peak = 0;
        for (int k = 0; k < mwm_pkg::WHEELS; k++)
        begin
            a = (sum[k] < 0) ? -sum[k] : sum[k];
            if (a > peak)
                peak = a;
        end
        for (int k = 0; k < mwm_pkg::WHEELS; k++)
        begin
            a = (sum[k] < 0) ? -sum[k] : sum[k];
            if (peak != 0 && peak > longint'(max_speed_cfg))
                a = (a * longint'(max_speed_cfg)) / peak;
            rpm = (a * longint'(gain_cfg) + (longint'(1) << 19)) >> 20;
            if (rpm > longint'(max_rpm_cfg))
                rpm = longint'(max_rpm_cfg);
            res[k] = (sum[k] < 0) ? mwm_pkg::RPM_W'(-rpm) : mwm_pkg::RPM_W'(rpm);
        end
        return res;
    endfunction

    function automatic int rand_speed();
        case ($urandom_range(9))
            0:       return 32767;
            1:       return -32768;
            2, 3:    return int'($urandom_range(8191)) - 4096;
            4:       return int'($urandom_range(32767)) - 16384;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    task automatic send_cmd(int h, int v, int r);
        @(negedge clk);
        while (cmd_gap_pct > 0 && $urandom_range(99) < cmd_gap_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid        <= 1'b1;
        speed_horizontal <= mwm_pkg::IN_W'(h);
        speed_vertical   <= mwm_pkg::IN_W'(v);
        speed_rotation   <= mwm_pkg::IN_W'(r);
        do
            @(posedge clk);
        while (cmd_stall);
        pending_rpm.push_back(mix_wheels(h, v, r));
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_cmd(rand_speed(), rand_speed(), rand_speed());
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_rpm.size() != 0)
            @(posedge clk);
        repeat (PIPE_CYCLES + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [mwm_pkg::APB_ADDR_W-1:0] addr,
                             logic [mwm_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (addr)
            mwm_pkg::ADDR_MAX_SPEED: max_speed_cfg = data[mwm_pkg::LIM_W-1:0];
            mwm_pkg::ADDR_GAIN:      gain_cfg      = data[mwm_pkg::GAIN_W-1:0];
            mwm_pkg::ADDR_MAX_RPM:   max_rpm_cfg   = data[mwm_pkg::LIM_W-1:0];
            default:                 ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(int speed_lim, int gain, int rpm_lim);
        write_reg(mwm_pkg::ADDR_MAX_SPEED, speed_lim);
        write_reg(mwm_pkg::ADDR_GAIN, gain);
        write_reg(mwm_pkg::ADDR_MAX_RPM, rpm_lim);
    endtask

    task automatic test_directed();
        send_cmd(0, 0, 0);
        send_cmd(4096, 0, 0);
        send_cmd(0, 4096, 0);
        send_cmd(0, 0, 4096);
        send_cmd(1, 1, 1);
        send_cmd(-1, -1, -1);
        send_cmd(32767, 0, 0);
        send_cmd(-32768, 0, 0);
        send_cmd(0, 32767, 0);
        send_cmd(0, -32768, 0);
        send_cmd(0, 0, 32767);
        send_cmd(0, 0, -32768);
        send_cmd(32767, 32767, 32767);
        send_cmd(-32768, -32768, -32768);
        send_cmd(32767, -32768, 32767);
        send_cmd(-32768, 32767, -32768);
        send_cmd(12288, 0, 0);
        send_cmd(12289, 0, 0);
        send_cmd(0, 12000, 0);
        send_cmd(0, 12288, 0);
        send_cmd(4096, -4096, 0);
        send_cmd(-1234, 2345, -3456);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        // zero chassis limit
        set_limits(0, int'(mwm_pkg::GAIN_RESET), int'(mwm_pkg::MAX_RPM_RESET));
        send_cmd(0, 0, 0);
        send_cmd(32767, -32768, 1);
        send_random(40);
        wait_drained();
        // zero rpm clamp
        set_limits(int'(mwm_pkg::MAX_SPEED_RESET), int'(mwm_pkg::GAIN_RESET), 0);
        send_random(40);
        wait_drained();
        set_limits(32767, 16777215, 32767);
        send_cmd(1, 0, 0);
        send_cmd(32767, 32767, 32767);
        send_random(40);
        wait_drained();
        set_limits(32767, 0, 32767);
        send_random(40);
        wait_drained();
        set_limits(1, 16777215, 32767);
        send_cmd(1, 0, 0);
        send_random(40);
        wait_drained();
        // unmapped address must leave the registers alone
        set_limits(int'(mwm_pkg::MAX_SPEED_RESET), int'(mwm_pkg::GAIN_RESET),
                   int'(mwm_pkg::MAX_RPM_RESET));
        write_reg(ADDR_UNUSED, 32'hFFFF_FFFF);
        send_random(40);
        wait_drained();
    endtask

    task automatic run_random_blocks(int blocks, int per_block);
        for (int b = 0; b < blocks; b++)
        begin
            if ($urandom_range(1))
                set_limits($urandom_range(32767), $urandom_range(16777215),
                           $urandom_range(32767));
            else
                set_limits($urandom_range(2048, 20000), $urandom_range(100000, 2000000),
                           $urandom_range(1000, 32767));
            send_random(per_block);
            wait_drained();
        end
    endtask

    task automatic test_sender_light_idle();
        cmd_gap_pct   = 13;
        rpm_stall_pct = 53;
        run_random_blocks(5, 100);
    endtask

    task automatic test_receiver_light_idle();
        cmd_gap_pct   = 53;
        rpm_stall_pct = 13;
        run_random_blocks(5, 100);
    endtask

    task automatic test_no_idle();
        cmd_gap_pct   = 0;
        rpm_stall_pct = 0;
        run_random_blocks(5, 100);
    endtask

    task automatic test_long_backpressure();
        cmd_gap_pct   = 0;
        rpm_stall_pct = 0;
        set_limits(int'(mwm_pkg::MAX_SPEED_RESET), int'(mwm_pkg::GAIN_RESET),
                   int'(mwm_pkg::MAX_RPM_RESET));
        hold_left = HOLD_CYCLES;
        send_random(100);
        wait_drained();
    endtask

    // result side: random stall plus the long hold-off
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rpm_stall <= 1'b1;
                hold_left--;
            end
            else
                rpm_stall <= (rpm_stall_pct > 0) && ($urandom_range(99) < rpm_stall_pct);
        end
    end

    initial
    begin
        wheel_rpm_t got;
        wheel_rpm_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rpm_valid && !rpm_stall)
            begin
                got[mwm_pkg::WHEEL_LF] = lf_rpm;
                got[mwm_pkg::WHEEL_LB] = lb_rpm;
                got[mwm_pkg::WHEEL_RF] = rf_rpm;
                got[mwm_pkg::WHEEL_RB] = rb_rpm;
                if (pending_rpm.size() == 0)
                begin
                    $error("result with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_rpm.pop_front();
                    for (int k = 0; k < mwm_pkg::WHEELS; k++)
                        if (got[k] !== want[k])
                        begin
                            $error("%s: expected %0d, got %0d", wheel_name[k],
                                   $signed(want[k]), $signed(got[k]));
                            mismatches++;
                        end
                end
            end
        end
    end

    initial
    begin
        max_speed_cfg = mwm_pkg::MAX_SPEED_RESET;
        gain_cfg      = mwm_pkg::GAIN_RESET;
        max_rpm_cfg   = mwm_pkg::MAX_RPM_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_limit_extremes();
        test_sender_light_idle();
        test_receiver_light_idle();
        test_no_idle();
        test_long_backpressure();

        if (mismatches == 0 && pending_rpm.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
